// ----- rtl/hnrc_pkg.sv -----
// ----------------------------------------------------------------------------
// hnrc_pkg
// Shared types, codes and port tables for the hierarchical route compute.
// ----------------------------------------------------------------------------
package hnrc_pkg;

  // Router levels
  localparam logic [1:0] LVL_MESH    = 2'd0;
  localparam logic [1:0] LVL_CLUSTER = 2'd1;
  localparam logic [1:0] LVL_LEAF    = 2'd2;

  // Destination kinds
  localparam logic [2:0] KIND_CSRAM = 3'd3;  // last tile-local kind
  localparam logic [2:0] KIND_CDMA  = 3'd4;
  localparam logic [2:0] KIND_EDGE  = 3'd5;

  // Port codes
  localparam logic [3:0] PORT_VERT  = 4'd0;  // mesh down / leaf up
  localparam logic [3:0] PORT_NORTH = 4'd1;
  localparam logic [3:0] PORT_EAST  = 4'd3;
  localparam logic [3:0] PORT_SOUTH = 4'd5;
  localparam logic [3:0] PORT_WEST  = 4'd7;
  localparam logic [3:0] PORT_CDMA  = 4'd8;

  localparam logic [1:0] MESH_CORNER_DOWN = 2'd2;

  localparam logic [3:0] EDGE_ROUTER [16] = '{
    4'd0, 4'd1, 4'd2, 4'd3, 4'd3, 4'd7, 4'd11, 4'd15,
    4'd15, 4'd14, 4'd13, 4'd12, 4'd12, 4'd8, 4'd4, 4'd0
  };
  localparam logic [3:0] EDGE_PORT [16] = '{
    4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd3, 4'd3, 4'd3,
    4'd5, 4'd5, 4'd5, 4'd5, 4'd7, 4'd7, 4'd7, 4'd7
  };
  localparam logic [3:0] MESH_CORNER_PORT [4] = '{4'd4, 4'd6, 4'd0, 4'd2};
  localparam logic [3:0] TILE_EJECT_PORT [4]  = '{4'd4, 4'd5, 4'd6, 4'd7};

  localparam int NUM_CAND = 4;

  typedef struct packed {
    logic [1:0] router_level;
    logic [5:0] router_index;
    logic [2:0] dest_kind;
    logic [5:0] dest_instance;
  } req_t;

  typedef struct packed {
    logic [3:0] port_sel;
    logic       bad_request;
  } rsp_t;

  // After decode
  typedef struct packed {
    logic       bad;
    logic [1:0] level;
    logic       hit;
    logic [3:0] local_port;
    logic [3:0] here;
    logic [3:0] tgt_mesh;
  } dec_t;

  // After distance stage
  typedef struct packed {
    logic                     bad;
    logic [1:0]               level;
    logic                     hit;
    logic [3:0]               local_port;
    logic [3:0]               step_port;
    logic [NUM_CAND-1:0][2:0] hops;
    logic [NUM_CAND-1:0]      cand_ok;
  } dst_t;

endpackage

// ----- rtl/hnrc_decode.sv -----
// ----------------------------------------------------------------------------
// hnrc_decode
// Stage 1: range checks, target mesh router and local eject port.
// ----------------------------------------------------------------------------
module hnrc_decode (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  hnrc_pkg::req_t  in_data,
  output logic            dec_valid,
  input  logic            dec_stall,
  output hnrc_pkg::dec_t  dec_data
);

  logic           valid_r;
  hnrc_pkg::dec_t data_r;
  hnrc_pkg::dec_t data_nxt;

  logic [1:0] lvl;
  logic [5:0] idx;
  logic [2:0] kind;
  logic [5:0] inst;
  logic [3:0] tgt_cluster;

  always_comb begin
    lvl  = in_data.router_level;
    idx  = in_data.router_index;
    kind = in_data.dest_kind;
    inst = in_data.dest_instance;

    tgt_cluster = (kind == hnrc_pkg::KIND_CDMA) ? inst[3:0] : inst[5:2];

    data_nxt.level = lvl;
    data_nxt.here  = idx[3:0];
    data_nxt.bad   = (lvl != hnrc_pkg::LVL_MESH && lvl != hnrc_pkg::LVL_CLUSTER &&
                      lvl != hnrc_pkg::LVL_LEAF) ||
                     (kind > hnrc_pkg::KIND_EDGE) ||
                     ((lvl == hnrc_pkg::LVL_MESH || lvl == hnrc_pkg::LVL_CLUSTER) &&
                      (idx[5:4] != 2'd0)) ||
                     ((kind == hnrc_pkg::KIND_CDMA || kind == hnrc_pkg::KIND_EDGE) &&
                      (inst[5:4] != 2'd0));
    data_nxt.tgt_mesh = (kind == hnrc_pkg::KIND_EDGE) ?
                        hnrc_pkg::EDGE_ROUTER[inst[3:0]] : tgt_cluster;

    unique case (lvl)
      hnrc_pkg::LVL_LEAF: begin
        data_nxt.hit        = (kind <= hnrc_pkg::KIND_CSRAM) && (inst == idx);
        data_nxt.local_port = {1'b0, kind} + 4'd1;
      end
      hnrc_pkg::LVL_CLUSTER: begin
        data_nxt.hit        = (kind != hnrc_pkg::KIND_EDGE) && (idx[3:0] == tgt_cluster);
        data_nxt.local_port = (kind == hnrc_pkg::KIND_CDMA) ?
                              hnrc_pkg::PORT_CDMA : hnrc_pkg::TILE_EJECT_PORT[inst[1:0]];
      end
      hnrc_pkg::LVL_MESH: begin
        data_nxt.hit        = (idx[3:0] == data_nxt.tgt_mesh);
        data_nxt.local_port = (kind == hnrc_pkg::KIND_EDGE) ?
                              hnrc_pkg::EDGE_PORT[inst[3:0]] :
                              hnrc_pkg::MESH_CORNER_PORT[hnrc_pkg::MESH_CORNER_DOWN];
      end
      default: begin
        data_nxt.hit        = 1'b0;
        data_nxt.local_port = hnrc_pkg::PORT_VERT;
      end
    endcase
  end

  assign in_stall = valid_r && dec_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dec_valid = valid_r;
  assign dec_data  = data_r;

endmodule

// ----- rtl/hnrc_dist.sv -----
// ----------------------------------------------------------------------------
// hnrc_dist
// Stage 2: XY step for mesh routers and distances from the cluster router's
// mesh neighbors to the target mesh router.
// ----------------------------------------------------------------------------
module hnrc_dist (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            dec_valid,
  output logic            dec_stall,
  input  hnrc_pkg::dec_t  dec_data,
  output logic            dst_valid,
  input  logic            dst_stall,
  output hnrc_pkg::dst_t  dst_data
);

  logic           valid_r;
  hnrc_pkg::dst_t data_r;
  hnrc_pkg::dst_t data_nxt;

  logic [1:0] row, col, trow, tcol;
  logic [1:0] crow, ccol, dr, dc;
  logic       up, left;

  always_comb begin
    row  = dec_data.here[3:2];
    col  = dec_data.here[1:0];
    trow = dec_data.tgt_mesh[3:2];
    tcol = dec_data.tgt_mesh[1:0];

    data_nxt.bad        = dec_data.bad;
    data_nxt.level      = dec_data.level;
    data_nxt.hit        = dec_data.hit;
    data_nxt.local_port = dec_data.local_port;

    // X first, then Y
    priority if (col < tcol) begin
      data_nxt.step_port = hnrc_pkg::PORT_EAST;
    end else if (col > tcol) begin
      data_nxt.step_port = hnrc_pkg::PORT_WEST;
    end else if (row < trow) begin
      data_nxt.step_port = hnrc_pkg::PORT_SOUTH;
    end else if (row > trow) begin
      data_nxt.step_port = hnrc_pkg::PORT_NORTH;
    end else begin
      data_nxt.step_port = hnrc_pkg::PORT_VERT;
    end

    // Neighbors in port order: NW, NE, SE, SW
    for (int c = 0; c < hnrc_pkg::NUM_CAND; c++) begin
      up   = (c == 0) || (c == 1);
      left = (c == 0) || (c == 3);
      crow = up ? row - 2'd1 : row;
      ccol = left ? col - 2'd1 : col;
      dr   = (crow > trow) ? crow - trow : trow - crow;
      dc   = (ccol > tcol) ? ccol - tcol : tcol - ccol;
      data_nxt.hops[c]    = {1'b0, dr} + {1'b0, dc};
      data_nxt.cand_ok[c] = !(up && row == 2'd0) && !(left && col == 2'd0);
    end
  end

  assign dec_stall = valid_r && dst_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!dec_stall) begin
      valid_r <= dec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!dec_stall && dec_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dst_valid = valid_r;
  assign dst_data  = data_r;

endmodule

// ----- rtl/hnrc_select.sv -----
// ----------------------------------------------------------------------------
// hnrc_select
// Stage 3: nearest-neighbor pick and final port mux into the output register.
// ----------------------------------------------------------------------------
module hnrc_select (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            dst_valid,
  output logic            dst_stall,
  input  hnrc_pkg::dst_t  dst_data,
  output logic            out_valid,
  input  logic            out_stall,
  output hnrc_pkg::rsp_t  out_data
);

  logic           valid_r;
  hnrc_pkg::rsp_t data_r;
  hnrc_pkg::rsp_t data_nxt;

  logic [2:0] best_d;
  logic [1:0] best_c;

  always_comb begin
    // lowest port wins a tie: strict compare in ascending order
    best_d = 3'd7;
    best_c = 2'd0;
    for (int c = 0; c < hnrc_pkg::NUM_CAND; c++) begin
      if (dst_data.cand_ok[c] && dst_data.hops[c] < best_d) begin
        best_d = dst_data.hops[c];
        best_c = 2'(c);
      end
    end

    data_nxt.bad_request = dst_data.bad;
    if (dst_data.bad) begin
      data_nxt.port_sel = hnrc_pkg::PORT_VERT;
    end else if (dst_data.hit) begin
      data_nxt.port_sel = dst_data.local_port;
    end else begin
      unique case (dst_data.level)
        hnrc_pkg::LVL_LEAF:    data_nxt.port_sel = hnrc_pkg::PORT_VERT;
        hnrc_pkg::LVL_CLUSTER: data_nxt.port_sel = {2'b00, best_c};
        hnrc_pkg::LVL_MESH:    data_nxt.port_sel = dst_data.step_port;
        default:               data_nxt.port_sel = hnrc_pkg::PORT_VERT;
      endcase
    end
  end

  assign dst_stall = valid_r && out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!dst_stall) begin
      valid_r <= dst_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!dst_stall && dst_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ----- rtl/hier_noc_route_compute.sv -----
// Three pipeline stages (decode, distance, select): a request passes their
// registers in order before its result shows on out_valid. Throughput: one
// request per cycle unless a held output backs up to the input. Each stage has
// its own valid bit, so a stalled output only backs up stages that hold data.
// Reset (rst_n low, synchronous) clears valid bits, not payload registers.
// ----------------------------------------------------------------------------
// hier_noc_route_compute
// Output-port computation for a hierarchical 4x4 network on chip.
// ----------------------------------------------------------------------------
module hier_noc_route_compute (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  hnrc_pkg::req_t  in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output hnrc_pkg::rsp_t  out_data
);

  logic           dec_valid, dec_stall;
  hnrc_pkg::dec_t dec_data;
  logic           dst_valid, dst_stall;
  hnrc_pkg::dst_t dst_data;

  hnrc_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .dec_valid (dec_valid),
    .dec_stall (dec_stall),
    .dec_data  (dec_data)
  );

  hnrc_dist u_dist (
    .clk       (clk),
    .rst_n     (rst_n),
    .dec_valid (dec_valid),
    .dec_stall (dec_stall),
    .dec_data  (dec_data),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .dst_data  (dst_data)
  );

  hnrc_select u_select (
    .clk       (clk),
    .rst_n     (rst_n),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .dst_data  (dst_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Flagged requests carry port 0
  a_bad_port_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.bad_request |-> out_data.port_sel == hnrc_pkg::PORT_VERT)
    else $error("bad request with nonzero port");

  a_port_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.port_sel <= hnrc_pkg::PORT_CDMA)
    else $error("port out of range");

  // Input backs up only when every stage is full and the output is held
  a_stall_full : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall && dec_valid && dst_valid)
    else $error("input stalled with a bubble in the pipeline");

  a_reset_clear : assert property (@(posedge clk)
    !rst_n |=> !out_valid && !dec_valid && !dst_valid)
    else $error("valid bits not cleared by reset");

endmodule

// ----- tb/hier_noc_route_compute_tb.sv -----
// ----------------------------------------------------------------------------
// hier_noc_route_compute_tb
// Self-checking bench for the hierarchical route compute. A short table of
// directed requests covers every level, every destination kind, the index
// extremes and each out-of-range case. Random requests follow in three
// phases of sender/receiver idling. Each result is compared, in order of
// acceptance, with a typed entry's result or an independent port predictor.
// ----------------------------------------------------------------------------
module hier_noc_route_compute_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hnrc_pkg::*;

  // Codes the package does not name
  localparam logic [1:0] LVL_RSVD   = 2'd3;
  localparam logic [2:0] KIND_PE    = 3'd0;
  localparam logic [2:0] KIND_TDMA  = 3'd1;
  localparam logic [2:0] KIND_TSRAM = 3'd2;
  localparam logic [2:0] KIND_RSVD6 = 3'd6;
  localparam logic [2:0] KIND_RSVD7 = 3'd7;

  // Own copies of the routing tables
  localparam int EXIT_ROUTER [16] = '{0, 1, 2, 3, 3, 7, 11, 15, 15, 14, 13, 12, 12, 8, 4, 0};
  localparam int EXIT_PORT   [16] = '{1, 1, 1, 1, 3, 3, 3, 3, 5, 5, 5, 5, 7, 7, 7, 7};
  localparam int TILE_EJECT  [4]  = '{4, 5, 6, 7};
  localparam int NBR_DROW    [4]  = '{-1, -1, 0, 0};
  localparam int NBR_DCOL    [4]  = '{-1, 0, 0, -1};

  localparam int RANDOM_PER_PHASE = 200;

  typedef struct {
    req_t req;
    logic typed;
    rsp_t rsp;
  } route_case_t;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_stall;
  req_t in_data   = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rsp_t out_data;

  rsp_t        pending_routes [$];
  route_case_t route_cases [$];
  rsp_t        want;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int          mismatch_count = 0;

  hier_noc_route_compute dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int grid_x(int m);
    return 2 * (m % 4) + 1;
  endfunction

  function automatic int grid_y(int m);
    return 2 * ((m / 4) % 4) + 1;
  endfunction

  function automatic rsp_t route_predict(req_t r);
    rsp_t p;
    int   tgt_mesh;
    int   tgt_cluster;
    int   here;
    int   row;
    int   col;
    int   rr;
    int   cc;
    int   m;
    int   d;
    int   best;
    logic tile_kind;
    p = '0;
    tgt_cluster = 0;
    here = int'(r.router_index);
    tile_kind = (r.dest_kind <= KIND_CSRAM);
    if (r.router_level == LVL_RSVD || r.dest_kind > KIND_EDGE) p.bad_request = 1'b1;
    if (r.router_level <= LVL_CLUSTER && r.router_index > 6'd15) p.bad_request = 1'b1;
    if ((r.dest_kind == KIND_CDMA || r.dest_kind == KIND_EDGE) && r.dest_instance > 6'd15)
      p.bad_request = 1'b1;
    if (!p.bad_request) begin
      if (r.dest_kind == KIND_EDGE) begin
        tgt_mesh = EXIT_ROUTER[r.dest_instance[3:0]];
      end else begin
        tgt_cluster = (r.dest_kind == KIND_CDMA) ? int'(r.dest_instance)
                                                 : int'(r.dest_instance[5:2]);
        tgt_mesh = tgt_cluster;
      end
      case (r.router_level)
        LVL_LEAF: begin
          if (tile_kind && r.dest_instance == r.router_index)
            p.port_sel = {1'b0, r.dest_kind} + 4'd1;
          else
            p.port_sel = PORT_VERT;
        end
        LVL_CLUSTER: begin
          if (r.dest_kind != KIND_EDGE && here == tgt_cluster) begin
            p.port_sel = (r.dest_kind == KIND_CDMA) ? PORT_CDMA
                                                    : 4'(TILE_EJECT[r.dest_instance[1:0]]);
          end else begin
            row = here / 4;
            col = here % 4;
            best = 1000;
            // strict compare keeps the lowest port on a tie
            for (int c = 0; c < 4; c++) begin
              rr = row + NBR_DROW[c];
              cc = col + NBR_DCOL[c];
              if (rr >= 0 && cc >= 0) begin
                m = rr * 4 + cc;
                d = ((grid_x(m) > grid_x(tgt_mesh)) ? grid_x(m) - grid_x(tgt_mesh)
                                                    : grid_x(tgt_mesh) - grid_x(m)) +
                    ((grid_y(m) > grid_y(tgt_mesh)) ? grid_y(m) - grid_y(tgt_mesh)
                                                    : grid_y(tgt_mesh) - grid_y(m));
                if (d < best) begin
                  best = d;
                  p.port_sel = 4'(c);
                end
              end
            end
          end
        end
        LVL_MESH: begin
          if (here == tgt_mesh)
            p.port_sel = (r.dest_kind == KIND_EDGE) ? 4'(EXIT_PORT[r.dest_instance[3:0]])
                                                    : PORT_VERT;
          else if (grid_x(here) < grid_x(tgt_mesh)) p.port_sel = PORT_EAST;
          else if (grid_x(here) > grid_x(tgt_mesh)) p.port_sel = PORT_WEST;
          else if (grid_y(here) < grid_y(tgt_mesh)) p.port_sel = PORT_SOUTH;
          else p.port_sel = PORT_NORTH;
        end
        default: p.port_sel = PORT_VERT;
      endcase
    end
    return p;
  endfunction

  function automatic req_t random_request();
    req_t r;
    r = req_t'($urandom);
    // leave noise as is; shape the rest into in-range headers
    if ($urandom_range(0, 99) >= 15) begin
      r.router_level = 2'($urandom_range(0, 2));
      r.router_index = (r.router_level == LVL_LEAF) ? 6'($urandom_range(0, 63))
                                                    : 6'($urandom_range(0, 15));
      r.dest_kind = 3'($urandom_range(0, 5));
      r.dest_instance = (r.dest_kind <= KIND_CSRAM) ? 6'($urandom_range(0, 63))
                                                    : 6'($urandom_range(0, 15));
      // steer a share towards local ejection
      if ($urandom_range(0, 3) == 0) begin
        if (r.router_level == LVL_LEAF && r.dest_kind <= KIND_CSRAM)
          r.dest_instance = r.router_index;
        else if (r.dest_kind == KIND_CDMA)
          r.dest_instance = r.router_index;
        else if (r.dest_kind <= KIND_CSRAM)
          r.dest_instance = {r.router_index[3:0], 2'($urandom_range(0, 3))};
      end
    end
    return r;
  endfunction

  task automatic add_case(input logic [1:0] lvl, input int idx, input logic [2:0] kind,
                          input int inst, input logic typed, input logic [3:0] port,
                          input logic bad);
    route_case_t rc;
    rc.req.router_level  = lvl;
    rc.req.router_index  = 6'(idx);
    rc.req.dest_kind     = kind;
    rc.req.dest_instance = 6'(inst);
    rc.typed             = typed;
    rc.rsp.port_sel      = port;
    rc.rsp.bad_request   = bad;
    route_cases = {route_cases, rc};
  endtask

  task automatic send_request(input req_t r, input logic typed, input rsp_t typed_rsp);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (in_stall !== 1'b0);
    pending_routes = {pending_routes, (typed ? typed_rsp : route_predict(r))};
  endtask

  // Result checker; out_stall is redrawn every cycle
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (pending_routes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected transaction: port %0d bad %0b",
                   out_data.port_sel, out_data.bad_request);
      end else begin
        want = pending_routes.pop_front();
        if (out_data.port_sel !== want.port_sel ||
            out_data.bad_request !== want.bad_request) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("route mismatch: expected port %0d bad %0b, got port %0d bad %0b",
                     want.port_sel, want.bad_request,
                     out_data.port_sel, out_data.bad_request);
        end
      end
    end
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  initial begin
    rsp_t no_rsp;
    no_rsp = '0;

    // leaf routers
    add_case(LVL_LEAF, 5, KIND_PE, 5, 1'b1, 4'd1, 1'b0);
    add_case(LVL_LEAF, 63, KIND_CSRAM, 63, 1'b1, 4'd4, 1'b0);
    add_case(LVL_LEAF, 0, KIND_TDMA, 0, 1'b1, 4'd2, 1'b0);
    add_case(LVL_LEAF, 0, KIND_TSRAM, 1, 1'b1, PORT_VERT, 1'b0);
    add_case(LVL_LEAF, 63, KIND_EDGE, 15, 1'b1, PORT_VERT, 1'b0);
    add_case(LVL_LEAF, 20, KIND_CDMA, 5, 1'b1, PORT_VERT, 1'b0);
    // cluster routers
    add_case(LVL_CLUSTER, 0, KIND_CDMA, 0, 1'b1, PORT_CDMA, 1'b0);
    add_case(LVL_CLUSTER, 15, KIND_CDMA, 15, 1'b1, PORT_CDMA, 1'b0);
    add_case(LVL_CLUSTER, 6, KIND_TSRAM, 26, 1'b0, 4'd0, 1'b0);
    add_case(LVL_CLUSTER, 5, KIND_CDMA, 3, 1'b0, 4'd0, 1'b0);
    add_case(LVL_CLUSTER, 15, KIND_EDGE, 0, 1'b0, 4'd0, 1'b0);
    add_case(LVL_CLUSTER, 1, KIND_PE, 20, 1'b0, 4'd0, 1'b0);
    add_case(LVL_CLUSTER, 4, KIND_EDGE, 3, 1'b0, 4'd0, 1'b0);
    // mesh routers
    add_case(LVL_MESH, 15, KIND_PE, 63, 1'b1, PORT_VERT, 1'b0);
    add_case(LVL_MESH, 0, KIND_PE, 63, 1'b1, PORT_EAST, 1'b0);
    add_case(LVL_MESH, 15, KIND_CDMA, 0, 1'b1, PORT_WEST, 1'b0);
    add_case(LVL_MESH, 3, KIND_CDMA, 15, 1'b1, PORT_SOUTH, 1'b0);
    add_case(LVL_MESH, 12, KIND_TDMA, 0, 1'b1, PORT_NORTH, 1'b0);
    add_case(LVL_MESH, 15, KIND_EDGE, 7, 1'b1, PORT_EAST, 1'b0);
    add_case(LVL_MESH, 0, KIND_EDGE, 15, 1'b1, PORT_WEST, 1'b0);
    // out-of-range requests
    add_case(LVL_RSVD, 63, KIND_RSVD7, 63, 1'b1, PORT_VERT, 1'b1);
    add_case(LVL_MESH, 16, KIND_PE, 0, 1'b1, PORT_VERT, 1'b1);
    add_case(LVL_CLUSTER, 63, KIND_TDMA, 0, 1'b1, PORT_VERT, 1'b1);
    add_case(LVL_LEAF, 7, KIND_RSVD6, 7, 1'b1, PORT_VERT, 1'b1);
    add_case(LVL_MESH, 2, KIND_CDMA, 16, 1'b1, PORT_VERT, 1'b1);
    add_case(LVL_LEAF, 9, KIND_EDGE, 63, 1'b1, PORT_VERT, 1'b1);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 45 : 0;
      recv_idle_pct = (phase == 0) ? 45 : (phase == 1) ? 9 : 0;
      if (phase == 0)
        foreach (route_cases[i])
          send_request(route_cases[i].req, route_cases[i].typed, route_cases[i].rsp);
      for (int n = 0; n < RANDOM_PER_PHASE; n++)
        send_request(random_request(), 1'b0, no_rsp);
    end
    in_valid <= 1'b0;

    // drain, then let the pipeline settle
    while (pending_routes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (mismatch_count == 0 && pending_routes.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
